>>> rtl/core/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property checked every clock edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold on the edge after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_PROP(lbl, prop, msg)

`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/core/tbt_pkg.sv
package tbt_pkg;

  localparam int NUM_BUCKETS_DEF = 16;
  localparam int TOKEN_BITS_DEF  = 24;

  localparam int CMD_W     = 3;
  localparam int SLOT_W    = 4;
  localparam int AMT_W     = 24;
  localparam int STATUS_W  = 2;
  // slots the slot field can name
  localparam int SLOT_SPAN = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_OPEN   = 3'd0,
    CMD_CLOSE  = 3'd1,
    CMD_TICK   = 3'd2,
    CMD_FETCH  = 3'd3,
    CMD_RETURN = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_SLOT = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ALU_NOP,
    ALU_TICK,
    ALU_FETCH,
    ALU_RETURN
  } alu_op_t;

  typedef struct packed {
    logic empty;
    logic sat;
  } alu_flags_t;

endpackage

>>> rtl/core/tbt_if.sv
interface tbt_in_if import tbt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SLOT_W-1:0] slot;
  logic [AMT_W-1:0]  amount;
  logic [AMT_W-1:0]  fill_rate;
  logic [AMT_W-1:0]  burst_limit;

  modport source (output valid, command, slot, amount, fill_rate, burst_limit, input ready);
  modport sink   (input valid, command, slot, amount, fill_rate, burst_limit, output ready);
endinterface

interface tbt_out_if import tbt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   granted_slot;
  logic [AMT_W-1:0]    granted;

  modport source (output valid, status, granted_slot, granted, input ready);
  modport sink   (input valid, status, granted_slot, granted, output ready);
endinterface

>>> rtl/core/token_bucket_table.sv
// channel   dir   payload                                          handshake
// in_chan   in    command, slot, amount, fill_rate, burst_limit    valid/ready
// out_chan  out   status, granted_slot, granted                    valid/ready
//
// open, close, fetch, return and unknown commands: each word is accepted, then executed
// tick: min(NUM_BUCKETS, 16) buckets, one bucket per cycle through the shared adder
// reset is synchronous and clears the slot flags; bucket storage is not reset
// ready is low while a word executes; a result waiting on out_chan holds the final
// step, and the next word is accepted once that result has moved to the output register
module token_bucket_table import tbt_pkg::*; #(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int TOKEN_BITS  = TOKEN_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tbt_in_if.sink    in_chan,
  tbt_out_if.source out_chan
);

  `include "assert_macros.svh"

  // only the slots the slot field can name are ever opened
  localparam int SPAN = NUM_BUCKETS < SLOT_SPAN ? NUM_BUCKETS : SLOT_SPAN;
  localparam int IW   = $clog2(SPAN);
  localparam int W    = (TOKEN_BITS > AMT_W ? TOKEN_BITS : AMT_W) + 1;
  localparam logic [IW-1:0]     LAST_IDX = IW'(SPAN - 1);
  localparam logic [SLOT_W:0]   SPAN_V   = (SLOT_W + 1)'(SPAN);
  localparam logic [W-1:0]      TMAX_W   = W'({TOKEN_BITS{1'b1}});

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t            state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic              bad_r, bad_nxt;
  logic [AMT_W-1:0]  amt_r, amt_nxt;
  logic [AMT_W-1:0]  fill_r, fill_nxt;
  logic [AMT_W-1:0]  blim_r, blim_nxt;
  logic [SPAN-1:0]   in_use_r, in_use_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [AMT_W-1:0]  out_grant_r, out_grant_nxt;

  logic [TOKEN_BITS-1:0] tok_mem   [SPAN];
  logic [TOKEN_BITS-1:0] rate_mem  [SPAN];
  logic [TOKEN_BITS-1:0] burst_mem [SPAN];

  logic [TOKEN_BITS-1:0] rd_tok_r;
  logic [TOKEN_BITS-1:0] rd_rate_r;
  logic [TOKEN_BITS-1:0] rd_burst_r;

  logic [SPAN-1:0]       low_free;
  logic                  table_full;
  logic [IW-1:0]         free_idx;
  logic [W-1:0]          fill_w;
  logic [W-1:0]          blim_w;
  logic [TOKEN_BITS-1:0] rate_sat;
  logic [TOKEN_BITS-1:0] burst_sat;

  alu_op_t               alu_op;
  logic [TOKEN_BITS-1:0] alu_tok;
  logic [AMT_W-1:0]      alu_grant;
  alu_flags_t            alu_flags;

  logic                  is_tick;
  logic                  last;
  logic                  out_free;
  logic                  step;
  logic                  finish;
  logic                  slot_open;
  status_t               status_v;
  logic [SLOT_W-1:0]     gslot_v;
  logic [AMT_W-1:0]      grant_v;
  logic                  mem_we;
  logic                  open_we;
  logic [IW-1:0]         mem_idx;
  logic [TOKEN_BITS-1:0] tok_wd;

  // lowest free slot: isolate the lowest zero of the flags
  assign low_free   = ~in_use_r & (in_use_r + SPAN'(1));
  assign table_full = &in_use_r;

  always_comb begin
    free_idx = '0;
    for (int i = 0; i < SPAN; i++) begin
      if (low_free[i]) free_idx = free_idx | IW'(i);
    end
  end

  always_comb begin
    fill_w    = W'(fill_r);
    blim_w    = W'(blim_r);
    rate_sat  = (fill_w > TMAX_W) ? TMAX_W[TOKEN_BITS-1:0] : fill_w[TOKEN_BITS-1:0];
    burst_sat = (blim_w > TMAX_W) ? TMAX_W[TOKEN_BITS-1:0] : blim_w[TOKEN_BITS-1:0];
  end

  always_comb begin
    case (cmd_r)
      CMD_TICK:   alu_op = ALU_TICK;
      CMD_FETCH:  alu_op = ALU_FETCH;
      CMD_RETURN: alu_op = ALU_RETURN;
      default:    alu_op = ALU_NOP;
    endcase
  end

  tbt_alu #(
    .TOKEN_BITS (TOKEN_BITS)
  ) u_alu (
    .op      (alu_op),
    .tok     (rd_tok_r),
    .rate    (rd_rate_r),
    .burst   (rd_burst_r),
    .amount  (amt_r),
    .new_tok (alu_tok),
    .grant   (alu_grant),
    .flags   (alu_flags)
  );

  assign is_tick   = (cmd_r == CMD_TICK);
  assign last      = !is_tick || (idx_r == LAST_IDX);
  assign out_free  = !out_valid_r || out_chan.ready;
  assign step      = (state_r == S_EXEC) && (!last || out_free);
  assign finish    = step && last;
  assign slot_open = !bad_r && in_use_r[idx_r];

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    bad_nxt        = bad_r;
    amt_nxt        = amt_r;
    fill_nxt       = fill_r;
    blim_nxt       = blim_r;
    in_use_nxt     = in_use_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_grant_nxt  = out_grant_r;
    status_v       = ST_OK;
    gslot_v        = '0;
    grant_v        = '0;
    mem_we         = 1'b0;
    open_we        = 1'b0;
    mem_idx        = idx_r;
    tok_wd         = alu_tok;

    if (state_r == S_IDLE) begin
      if (in_chan.valid) begin
        cmd_nxt   = in_chan.command;
        bad_nxt   = ({1'b0, in_chan.slot} >= SPAN_V);
        idx_nxt   = (in_chan.command == CMD_TICK || {1'b0, in_chan.slot} >= SPAN_V) ?
                    '0 : in_chan.slot[IW-1:0];
        amt_nxt   = in_chan.amount;
        fill_nxt  = in_chan.fill_rate;
        blim_nxt  = in_chan.burst_limit;
        state_nxt = S_EXEC;
      end
    end else if (step) begin
      case (cmd_r)
        CMD_OPEN: begin
          if (table_full) begin
            status_v = ST_FULL;
          end else begin
            mem_we               = 1'b1;
            open_we              = 1'b1;
            mem_idx              = free_idx;
            tok_wd               = '0;
            in_use_nxt[free_idx] = 1'b1;
            gslot_v              = SLOT_W'(free_idx);
          end
        end
        CMD_CLOSE: begin
          if (!slot_open) status_v = ST_BAD_SLOT;
          else in_use_nxt[idx_r] = 1'b0;
        end
        CMD_TICK: begin
          mem_we = in_use_r[idx_r];
          if (!last) idx_nxt = idx_r + IW'(1);
        end
        CMD_FETCH: begin
          if (!slot_open) begin
            status_v = ST_BAD_SLOT;
          end else if (alu_flags.empty) begin
            status_v = ST_EMPTY;
          end else begin
            mem_we  = 1'b1;
            grant_v = alu_grant;
          end
        end
        CMD_RETURN: begin
          if (!slot_open) begin
            status_v = ST_BAD_SLOT;
          end else begin
            mem_we  = 1'b1;
            grant_v = alu_grant;
          end
        end
        default: ;
      endcase

      if (last) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = status_v;
        out_slot_nxt   = gslot_v;
        out_grant_nxt  = grant_v;
        state_nxt      = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      in_use_r     <= in_use_nxt;
      out_valid_r  <= out_valid_nxt;
      cmd_r        <= cmd_nxt;
      idx_r        <= idx_nxt;
      bad_r        <= bad_nxt;
      amt_r        <= amt_nxt;
      fill_r       <= fill_nxt;
      blim_r       <= blim_nxt;
      out_status_r <= out_status_nxt;
      out_slot_r   <= out_slot_nxt;
      out_grant_r  <= out_grant_nxt;
    end
  end

  // bucket store; the read follows the next index so the data lines up with idx_r
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tok_mem[mem_idx] <= tok_wd;
      if (open_we) begin
        rate_mem[mem_idx]  <= rate_sat;
        burst_mem[mem_idx] <= burst_sat;
      end
    end
    rd_tok_r   <= tok_mem[idx_nxt];
    rd_rate_r  <= rate_mem[idx_nxt];
    rd_burst_r <= burst_mem[idx_nxt];
  end

  assign in_chan.ready         = (state_r == S_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.granted_slot = out_slot_r;
  assign out_chan.granted      = out_grant_r;

  `ASSERT_NEXT(a_busy_after_accept, in_chan.valid && in_chan.ready, !in_chan.ready, "ready straight after accepting a word")
  `ASSERT_NEXT(a_open_claims_slot, finish && cmd_r == CMD_OPEN && !table_full, in_use_r[$past(free_idx)], "open did not claim its slot")
  `ASSERT_PROP(a_grant_bounded, (finish && slot_open && (cmd_r == CMD_FETCH || cmd_r == CMD_RETURN)) |-> (alu_grant <= amt_r), "grant exceeds amount")
  `ASSERT_NEXT(a_bad_slot_no_change, finish && status_v == ST_BAD_SLOT, $stable(in_use_r), "slot flags changed on a bad slot")

endmodule

>>> rtl/core/tbt_alu.sv
module tbt_alu import tbt_pkg::*; #(
  parameter int TOKEN_BITS = TOKEN_BITS_DEF
) (
  input  alu_op_t               op,
  input  logic [TOKEN_BITS-1:0] tok,
  input  logic [TOKEN_BITS-1:0] rate,
  input  logic [TOKEN_BITS-1:0] burst,
  input  logic [AMT_W-1:0]      amount,
  output logic [TOKEN_BITS-1:0] new_tok,
  output logic [AMT_W-1:0]      grant,
  output alu_flags_t            flags
);

  localparam int W = (TOKEN_BITS > AMT_W ? TOKEN_BITS : AMT_W) + 1;

  logic [W-1:0] opa;
  logic [W-1:0] opb;
  logic         sub;
  logic [W-1:0] res;
  logic [W-1:0] inv_tok;
  logic         neg;
  logic         over;

  // one shared adder, subtracting for fetch
  always_comb begin
    opa     = W'(tok);
    opb     = (op == ALU_TICK) ? W'(rate) : W'(amount);
    sub     = (op == ALU_FETCH);
    res     = opa + (sub ? ~opb : opb) + W'(sub);
    inv_tok = W'(~tok);
    neg     = res[W-1];
    over    = |res[W-1:TOKEN_BITS];
  end

  always_comb begin
    new_tok     = tok;
    grant       = '0;
    flags.empty = (tok == '0);
    flags.sat   = 1'b0;
    case (op)
      ALU_TICK: begin
        new_tok = (res > W'(burst)) ? burst : res[TOKEN_BITS-1:0];
      end
      ALU_FETCH: begin
        if (neg || res == '0) begin
          new_tok = '0;
          grant   = opa[AMT_W-1:0];
        end else begin
          new_tok = res[TOKEN_BITS-1:0];
          grant   = amount;
        end
      end
      ALU_RETURN: begin
        flags.sat = over;
        if (over) begin
          // clamp at the all-ones count; what fitted is max minus old
          new_tok = '1;
          grant   = inv_tok[AMT_W-1:0];
        end else begin
          new_tok = res[TOKEN_BITS-1:0];
          grant   = amount;
        end
      end
      default: ;
    endcase
  end

endmodule
